// ===== design/per_domain_rate_limiter_assert.svh =====
// assertion macros shared by the rate limiter checker
// no dependencies; include guard below
`ifndef PER_DOMAIN_RATE_LIMITER_ASSERT_SVH
`define PER_DOMAIN_RATE_LIMITER_ASSERT_SVH

// same-cycle implication, sampled on the rising clock edge
`define PRL_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on the rising clock edge
`define PRL_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/prl_pkg.sv =====
// shared constants, codes and types of the per-domain rate limiter
// no dependencies
`default_nettype none

package prl_pkg;

    // table geometry
    localparam int ENTRIES  = 64;
    localparam int ID_BITS  = 32;

    // field widths
    localparam int KIND_W   = 2;
    localparam int DOMAIN_W = 32;
    localparam int RATE_W   = 32;
    localparam int TICK_W   = 64;
    localparam int STATUS_W = 3;

    // derived widths
    localparam int KEY_W = (ID_BITS < DOMAIN_W) ? ID_BITS : DOMAIN_W;
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    // decoupling queue, depth must be a power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // transaction kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR = 2'd0,
        KIND_LOAD  = 2'd1,
        KIND_REQ   = 2'd2
    } t_kind;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_ADMIT   = 3'd0,
        ST_UNKNOWN = 3'd1,
        ST_OFF     = 3'd2,
        ST_EARLY   = 3'd3,
        ST_DONE    = 3'd4,
        ST_FULL    = 3'd5
    } t_status;

    // classified transaction held in the queue
    typedef struct packed {
        t_kind              kind;
        logic [KEY_W-1:0]   key;
        logic               enabled;
        logic [TICK_W-1:0]  tick;
    } t_item;

    // back-end sequencer states
    typedef enum logic {
        BK_IDLE,
        BK_SCAN
    } t_back_state;

endpackage

`default_nettype wire

// ===== design/per_domain_rate_limiter.sv =====
// Per-domain rate limiter. A front end decodes each transaction and places it
// in a two-entry queue; a back end executes it against a domain table held in
// two memories (key with enable flag, next-allowed tick) and registers one
// result. Clear and load transactions complete in the back end without a scan.
// An admission request on an empty table gives unknown without a scan; any
// other request scans the table in load order up to the first match or the end
// of the table: the key memory delivers one entry per cycle, and the scan holds
// on its final entry while the result register is stalled. Undefined kind code
// 3 is accepted and produces no result.
// Table memories need no clearing after reset; the entry count bounds reads.
// depends on prl_pkg, prl_front, prl_queue, prl_back
`default_nettype none

module per_domain_rate_limiter (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [prl_pkg::KIND_W-1:0]    i_kind,
    input  wire logic [prl_pkg::DOMAIN_W-1:0]  i_domain_id,
    input  wire logic [prl_pkg::RATE_W-1:0]    i_rate,
    input  wire logic [prl_pkg::TICK_W-1:0]    i_tick,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic                               o_admitted,
    output logic [prl_pkg::STATUS_W-1:0]       o_status
);
    import prl_pkg::*;

    logic  push;
    t_item push_item;
    logic  q_full;
    logic  q_valid;
    t_item q_item;
    logic  q_pop;

    // decode and classify
    prl_front u_front (
        .i_valid     (i_valid),
        .i_kind      (i_kind),
        .i_domain_id (i_domain_id),
        .i_rate      (i_rate),
        .i_tick      (i_tick),
        .i_q_full    (q_full),
        .o_stall     (o_stall),
        .o_push      (push),
        .o_item      (push_item)
    );

    // decoupling queue
    prl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // table execution and result register
    prl_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_item   (q_item),
        .o_q_pop    (q_pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_admitted (o_admitted),
        .o_status   (o_status)
    );

endmodule

`default_nettype wire

// ===== design/prl_ram.sv =====
// generic single-write, single-read memory with registered read data
// no dependencies
`default_nettype none

module prl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== design/prl_front.sv =====
// front end: accepts transactions, decodes the kind and builds the queue entry
// depends on prl_pkg
`default_nettype none

module prl_front (
    input  wire logic                          i_valid,
    input  wire logic [prl_pkg::KIND_W-1:0]    i_kind,
    input  wire logic [prl_pkg::DOMAIN_W-1:0]  i_domain_id,
    input  wire logic [prl_pkg::RATE_W-1:0]    i_rate,
    input  wire logic [prl_pkg::TICK_W-1:0]    i_tick,
    input  wire logic                          i_q_full,
    output logic                               o_stall,
    output logic                               o_push,
    output prl_pkg::t_item                     o_item
);
    import prl_pkg::*;

    logic keep;

    // only the three defined kinds produce work; the unused code is swallowed
    always_comb begin
        unique case (i_kind) inside
            KIND_CLEAR, KIND_LOAD, KIND_REQ: keep = 1'b1;
            default:                         keep = 1'b0;
        endcase
    end

    // classify: trim the key, reduce the rate to an enable flag
    always_comb begin
        o_item.kind    = t_kind'(i_kind);
        o_item.key     = i_domain_id[KEY_W-1:0];
        o_item.enabled = (i_rate != '0);
        o_item.tick    = i_tick;
    end

    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full && keep;

endmodule

`default_nettype wire

// ===== design/prl_queue.sv =====
// short decoupling queue between the front end and the back end
// depends on prl_pkg
`default_nettype none

module prl_queue (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire prl_pkg::t_item i_item,
    input  wire logic   i_pop,
    output logic        o_full,
    output logic        o_valid,
    output prl_pkg::t_item o_item
);
    import prl_pkg::*;

    t_item              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wp, n_wp;
    logic [QPTR_W-1:0]  r_rp, n_rp;
    logic [QCNT_W-1:0]  r_cnt, n_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // pointer and fill bookkeeping
    always_comb begin
        n_wp  = do_push ? r_wp + QPTR_W'(1) : r_wp;
        n_rp  = do_pop  ? r_rp + QPTR_W'(1) : r_rp;
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== design/prl_back.sv =====
// back end: executes clear, load and admission transactions on the domain table
// depends on prl_pkg and prl_ram
`default_nettype none

module prl_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_q_valid,
    input  wire prl_pkg::t_item                i_q_item,
    output logic                               o_q_pop,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic                               o_admitted,
    output logic [prl_pkg::STATUS_W-1:0]       o_status
);
    import prl_pkg::*;

    t_back_state         r_state, n_state;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_out_valid;
    logic                r_out_adm;
    t_status             r_out_st;

    logic                slot_free;
    logic                table_full;
    logic                last_entry;
    logic                key_hit;
    logic                ent_enabled;
    logic                too_early;

    logic                res_fire;
    logic                res_adm;
    t_status             res_st;

    logic                tab_we;
    logic [IDX_W-1:0]    tab_waddr;
    logic [KEY_W:0]      key_wdata;
    logic [TICK_W-1:0]   tick_wdata;
    logic                tick_we;
    logic [IDX_W-1:0]    tick_waddr;
    logic [IDX_W-1:0]    raddr;
    logic [KEY_W:0]      key_rdata;
    logic [TICK_W-1:0]   tick_rdata;

    // key table: enable flag on top of the key
    prl_ram #(
        .WIDTH (KEY_W + 1),
        .DEPTH (ENTRIES)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (tab_we),
        .i_waddr (tab_waddr),
        .i_wdata (key_wdata),
        .i_raddr (raddr),
        .o_rdata (key_rdata)
    );

    // next-allowed tick table
    prl_ram #(
        .WIDTH (TICK_W),
        .DEPTH (ENTRIES)
    ) u_tick_ram (
        .i_clk   (i_clk),
        .i_we    (tick_we),
        .i_waddr (tick_waddr),
        .i_wdata (tick_wdata),
        .i_raddr (raddr),
        .o_rdata (tick_rdata)
    );

    // entry under examination and table status
    assign slot_free   = !r_out_valid || !i_stall;
    assign table_full  = (r_count == CNT_W'(ENTRIES));
    assign last_entry  = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);
    assign key_hit     = (key_rdata[KEY_W-1:0] == i_q_item.key);
    assign ent_enabled = key_rdata[KEY_W];
    assign too_early   = (i_q_item.tick < tick_rdata);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_q_valid && i_q_item.kind == KIND_REQ && r_count != '0) begin
                    n_state = BK_SCAN;
                end
            end
            BK_SCAN: begin
                if (o_q_pop) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // datapath control and results
    always_comb begin
        o_q_pop    = 1'b0;
        res_fire   = 1'b0;
        res_adm    = 1'b0;
        res_st     = ST_DONE;
        tab_we     = 1'b0;
        tab_waddr  = r_count[IDX_W-1:0];
        key_wdata  = {i_q_item.enabled, i_q_item.key};
        tick_we    = 1'b0;
        tick_waddr = r_count[IDX_W-1:0];
        tick_wdata = '0;
        raddr      = r_idx;
        n_idx      = r_idx;
        n_count    = r_count;
        unique case (r_state)
            BK_IDLE: begin
                raddr = '0;
                n_idx = '0;
                if (i_q_valid) begin
                    unique case (i_q_item.kind)
                        KIND_CLEAR: begin
                            if (slot_free) begin
                                n_count  = '0;
                                res_fire = 1'b1;
                                res_st   = ST_DONE;
                                o_q_pop  = 1'b1;
                            end
                        end
                        KIND_LOAD: begin
                            if (slot_free) begin
                                res_fire = 1'b1;
                                o_q_pop  = 1'b1;
                                if (table_full) begin
                                    res_st = ST_FULL;
                                end else begin
                                    tab_we  = 1'b1;
                                    tick_we = 1'b1;
                                    n_count = r_count + CNT_W'(1);
                                    res_st  = ST_DONE;
                                end
                            end
                        end
                        KIND_REQ: begin
                            // empty table: unknown without a scan
                            if (r_count == '0 && slot_free) begin
                                res_fire = 1'b1;
                                res_st   = ST_UNKNOWN;
                                o_q_pop  = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            BK_SCAN: begin
                if (key_hit) begin
                    if (slot_free) begin
                        res_fire = 1'b1;
                        o_q_pop  = 1'b1;
                        if (!ent_enabled) begin
                            res_st = ST_OFF;
                        end else if (too_early) begin
                            res_st = ST_EARLY;
                        end else begin
                            res_st     = ST_ADMIT;
                            res_adm    = 1'b1;
                            tick_we    = 1'b1;
                            tick_waddr = r_idx;
                            tick_wdata = i_q_item.tick + TICK_W'(1);
                        end
                    end
                end else if (last_entry) begin
                    if (slot_free) begin
                        res_fire = 1'b1;
                        res_st   = ST_UNKNOWN;
                        o_q_pop  = 1'b1;
                    end
                end else begin
                    // move on to the next entry
                    n_idx = r_idx + IDX_W'(1);
                    raddr = n_idx;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_idx       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_count <= n_count;
            if (res_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (res_fire) begin
            r_out_adm <= res_adm;
            r_out_st  <= res_st;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_admitted = r_out_adm;
    assign o_status   = r_out_st;

endmodule

`default_nettype wire

// ===== design/prl_checker.sv =====
// port-level checks for the per-domain rate limiter, bound to the top level
// depends on prl_pkg and per_domain_rate_limiter_assert.svh
`default_nettype none

`include "per_domain_rate_limiter_assert.svh"

module prl_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic                          o_stall,
    input  wire logic [prl_pkg::KIND_W-1:0]    i_kind,
    input  wire logic [prl_pkg::DOMAIN_W-1:0]  i_domain_id,
    input  wire logic [prl_pkg::RATE_W-1:0]    i_rate,
    input  wire logic [prl_pkg::TICK_W-1:0]    i_tick,
    input  wire logic                          o_valid,
    input  wire logic                          i_stall,
    input  wire logic                          o_admitted,
    input  wire logic [prl_pkg::STATUS_W-1:0]  o_status
);
    import prl_pkg::*;

    // a stalled result stays offered
    `PRL_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid, "result dropped while stalled")

    // a stalled result keeps its payload
    `PRL_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, o_valid && i_stall, $stable(o_admitted) && $stable(o_status), "result changed while stalled")

    // admitted flag agrees with the status code
    `PRL_ASSERT_IMP(a_adm_status, i_clk, i_rst_n, o_valid, o_admitted == (o_status == ST_ADMIT), "admitted flag disagrees with status")

    // no result in the first cycle after reset
    `PRL_ASSERT_IMP(a_reset_quiet, i_clk, i_rst_n, $past(!i_rst_n), !o_valid, "result offered straight after reset")

endmodule

bind per_domain_rate_limiter prl_checker u_prl_checker (.*);

`default_nettype wire

// ===== verif/prl_admission_checker.sv =====
`timescale 1ns / 1ps
// checker for the per-domain rate limiter: watches both channels, predicts every
// verdict from its own copy of the domain table and compares results in order
// depends on prl_pkg
module prl_admission_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic [prl_pkg::KIND_W-1:0]     i_kind,
    input  logic [prl_pkg::DOMAIN_W-1:0]   i_domain_id,
    input  logic [prl_pkg::RATE_W-1:0]     i_rate,
    input  logic [prl_pkg::TICK_W-1:0]     i_tick,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic                           i_admitted,
    input  logic [prl_pkg::STATUS_W-1:0]   i_status,
    output int                             o_fail_count,
    output int                             o_outstanding
);
    import prl_pkg::*;

    typedef struct packed {
        logic    admitted;
        t_status status;
    } t_verdict;

    localparam int REPORT_LIMIT = 10;

    // private copy of the domain table
    logic [KEY_W-1:0]  dom_keys    [ENTRIES];
    logic              dom_enabled [ENTRIES];
    logic [TICK_W-1:0] dom_next    [ENTRIES];
    int unsigned       dom_count = 0;

    t_verdict expected_verdicts[$];
    int       fail_count = 0;
    int       reported   = 0;

    // apply one transaction to the table and queue the verdict it should give
    task automatic predict_admission(input logic [KIND_W-1:0] kind,
                                     input logic [KEY_W-1:0] key,
                                     input logic [RATE_W-1:0] rate,
                                     input logic [TICK_W-1:0] tick);
        t_verdict    v;
        bit          hit;
        int unsigned i;
        v.admitted = 1'b0;
        v.status   = ST_DONE;
        hit        = 1'b0;
        case (kind)
            KIND_CLEAR: begin
                dom_count = 0;
            end
            KIND_LOAD: begin
                if (dom_count >= ENTRIES) begin
                    v.status = ST_FULL;
                end else begin
                    dom_keys[dom_count]    = key;
                    dom_enabled[dom_count] = (rate != '0);
                    dom_next[dom_count]    = '0;
                    dom_count++;
                end
            end
            KIND_REQ: begin
                v.status = ST_UNKNOWN;
                // first entry in load order wins
                for (i = 0; i < dom_count && !hit; i++) begin
                    if (dom_keys[i] == key) begin
                        hit = 1'b1;
                        if (!dom_enabled[i]) begin
                            v.status = ST_OFF;
                        end else if (tick < dom_next[i]) begin
                            v.status = ST_EARLY;
                        end else begin
                            dom_next[i] = tick + 1'b1;
                            v.admitted  = 1'b1;
                            v.status    = ST_ADMIT;
                        end
                    end
                end
            end
            default: begin
                // undefined kind: no result
                return;
            end
        endcase
        expected_verdicts = {expected_verdicts, v};
    endtask

    // compare results, then record newly accepted transactions
    always @(posedge i_clk) begin : monitor
        t_verdict want;
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_verdicts.size() == 0) begin
                    fail_count++;
                    if (reported < REPORT_LIMIT) begin
                        reported++;
                        $display("%0t: unexpected result admitted=%0d status=%0d",
                                 $realtime, i_admitted, i_status);
                    end
                end else begin
                    want = expected_verdicts.pop_front();
                    if (i_admitted !== want.admitted || i_status !== want.status) begin
                        fail_count++;
                        if (reported < REPORT_LIMIT) begin
                            reported++;
                            $display({"%0t: mismatch admitted exp=%0d got=%0d,",
                                      " status exp=%0d got=%0d"},
                                     $realtime, want.admitted, i_admitted,
                                     want.status, i_status);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_admission(i_kind, i_domain_id[KEY_W-1:0], i_rate, i_tick);
            end
        end
        o_fail_count  <= fail_count;
        o_outstanding <= expected_verdicts.size();
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// top of the rate limiter testbench: clock, reset, directed and random
// transactions with random pacing on both channels, watchdog and verdict
// depends on prl_pkg, per_domain_rate_limiter, prl_admission_checker
module tb;
    import prl_pkg::*;

    localparam int NUM_ITEMS    = 1550;
    localparam int MAX_WAIT     = 12;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 100;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [KIND_W-1:0]   i_kind;
    logic [DOMAIN_W-1:0] i_domain_id;
    logic [RATE_W-1:0]   i_rate;
    logic [TICK_W-1:0]   i_tick;
    logic                o_valid;
    logic                i_stall;
    logic                o_admitted;
    logic [STATUS_W-1:0] o_status;

    int fail_count;
    int outstanding;
    int idle_cycles = 0;
    int sent        = 0;
    bit calm        = 1'b0;

    // ids loaded since the last clear, used to aim requests at real entries
    logic [DOMAIN_W-1:0] known_ids[$];
    logic [TICK_W-1:0]   now_tick = '0;

    always #4 i_clk = ~i_clk;

    per_domain_rate_limiter u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_kind      (i_kind),
        .i_domain_id (i_domain_id),
        .i_rate      (i_rate),
        .i_tick      (i_tick),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_admitted  (o_admitted),
        .o_status    (o_status)
    );

    prl_admission_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_kind        (i_kind),
        .i_domain_id   (i_domain_id),
        .i_rate        (i_rate),
        .i_tick        (i_tick),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_admitted    (o_admitted),
        .i_status      (o_status),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("per_domain_rate_limiter test failed");
            $finish;
        end
    end

    // result side back-pressure, one random hold-off per result
    initial begin : out_pacing
        int w;
        wait (i_rst_n === 1'b1);
        forever begin
            w = calm ? 0 : $urandom_range(0, MAX_WAIT);
            if (w > 0) begin
                @(negedge i_clk);
                i_stall <= 1'b1;
                repeat (w - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_valid && !i_stall));
        end
    end

    // drive one transaction after a random gap and wait for its acceptance
    task automatic send_txn(input logic [KIND_W-1:0] kind,
                            input logic [DOMAIN_W-1:0] id,
                            input logic [RATE_W-1:0] rate,
                            input logic [TICK_W-1:0] tick);
        int gap;
        gap = calm ? 0 : $urandom_range(0, MAX_WAIT);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_kind      <= kind;
        i_domain_id <= id;
        i_rate      <= rate;
        i_tick      <= tick;
        do @(posedge i_clk); while (o_stall);
        if (kind == KIND_CLEAR) begin
            known_ids.delete();
        end else if (kind == KIND_LOAD && known_ids.size() < ENTRIES) begin
            known_ids = {known_ids, id};
        end
        if (kind != KIND_UNUSED) begin
            sent++;
        end
    endtask

    // request aimed mostly at loaded ids, ticks mostly near a running time
    task automatic send_request();
        logic [DOMAIN_W-1:0] id;
        logic [TICK_W-1:0]   tick;
        if (known_ids.size() > 0 && $urandom_range(0, 4) != 0) begin
            id = known_ids[$urandom_range(0, known_ids.size() - 1)];
        end else begin
            id = $urandom;
        end
        now_tick = now_tick + $urandom_range(0, 2);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: tick = now_tick + $urandom_range(0, 2);
            5, 6:          tick = now_tick - $urandom_range(1, 3);
            7:             tick = {$urandom, $urandom};
            8:             tick = '1;
            default:       tick = $urandom_range(0, 3);
        endcase
        send_txn(KIND_REQ, id, $urandom, tick);
    endtask

    initial begin : stimulus
        int                  n_loads;
        int                  r;
        int                  phase_no;
        logic [DOMAIN_W-1:0] id;
        logic [RATE_W-1:0]   rate;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_kind      = KIND_CLEAR;
        i_domain_id = '0;
        i_rate      = '0;
        i_tick      = '0;
        i_stall     = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, disabled domain, early, tick wrap, duplicates
        send_txn(KIND_CLEAR, '0, '0, '0);
        send_txn(KIND_REQ, 32'h1234_5678, '0, '0);
        send_txn(KIND_LOAD, 32'h0000_0000, 32'h0000_0000, '1);
        send_txn(KIND_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
        send_txn(KIND_LOAD, 32'hA5A5_5A5A, 32'h0000_0001, '0);
        send_txn(KIND_REQ, 32'h0000_0000, '1, '0);
        send_txn(KIND_REQ, 32'hFFFF_FFFF, '0, '0);
        send_txn(KIND_REQ, 32'hFFFF_FFFF, '0, '0);
        send_txn(KIND_REQ, 32'hFFFF_FFFF, '0, '1);
        send_txn(KIND_REQ, 32'hFFFF_FFFF, '0, '0);
        send_txn(KIND_LOAD, 32'hFFFF_FFFF, 32'h0000_0000, '0);
        send_txn(KIND_REQ, 32'hFFFF_FFFF, '0, 64'h8000_0000_0000_0000);
        send_txn(KIND_REQ, 32'hA5A5_5A5A, '0, '1);
        send_txn(KIND_REQ, 32'hA5A5_5A5A, '0, '0);
        send_txn(KIND_UNUSED, '1, '1, '1);
        send_txn(KIND_REQ, 32'h5A5A_A5A5, '1, '1);
        send_txn(KIND_CLEAR, '1, '1, '1);
        send_txn(KIND_REQ, 32'hFFFF_FFFF, '0, '1);

        // random phases: clear (skipped now and then), fill, then a burst of requests with some noise
        phase_no = 0;
        while (sent < NUM_ITEMS) begin
            calm = ($urandom_range(0, 4) == 0);
            if (phase_no == 0 || $urandom_range(0, 9) != 0) begin
                send_txn(KIND_CLEAR, $urandom, $urandom, {$urandom, $urandom});
            end
            n_loads = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 70)
                                                  : $urandom_range(1, 12);
            repeat (n_loads) begin
                if (known_ids.size() > 0 && $urandom_range(0, 9) == 0) begin
                    id = known_ids[$urandom_range(0, known_ids.size() - 1)];
                end else begin
                    id = $urandom;
                end
                case ($urandom_range(0, 3))
                    0:       rate = '0;
                    1:       rate = '1;
                    default: rate = $urandom;
                endcase
                send_txn(KIND_LOAD, id, rate, {$urandom, $urandom});
            end
            repeat ($urandom_range(10, 40)) begin
                r = $urandom_range(0, 99);
                if (r < 4) begin
                    send_txn(KIND_UNUSED, $urandom, $urandom, {$urandom, $urandom});
                end else if (r < 6) begin
                    send_txn(KIND_LOAD, $urandom, $urandom, {$urandom, $urandom});
                end else if (r < 7) begin
                    send_txn(KIND_CLEAR, $urandom, $urandom, {$urandom, $urandom});
                end else begin
                    send_request();
                end
            end
            phase_no++;
        end

        // drain and give the verdict
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("per_domain_rate_limiter test passed");
        end else begin
            $display("per_domain_rate_limiter test failed");
        end
        $finish;
    end

endmodule
